>>> src/midpoint_circle_arc_plotter_core_defines.svh
// ----------------------------------------------------------------------------
// midpoint circle arc plotter - assertion macros
// shared concurrent check shorthands, sampled on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_ARC_PLOTTER_CORE_DEFINES_SVH
`define MIDPOINT_CIRCLE_ARC_PLOTTER_CORE_DEFINES_SVH

// condition must hold at every edge out of reset
`define MCAP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define MCAP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> src/mcap_pkg.sv
// ----------------------------------------------------------------------------
// mcap_pkg
// shared constants, types and the quarter-wave sine table for the arc plotter
// ----------------------------------------------------------------------------
package mcap_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int ANGLE_W         = 9;
  localparam int ANGLE_MAX       = 360;
  localparam int OCT_SPAN        = 45;
  localparam int OCT_W           = 4;
  localparam int REM_W           = 6;
  localparam int SIN_W           = 16;
  localparam int DEG_W           = 7;
  localparam int QUEUE_DEPTH     = 4;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int S_DATA_W   = 8;
  // output data width at the default radius
  localparam int M_DATA_W   = ((2 * (RADIUS_BITS_DEF + 1) + 7) / 8) * 8;
  localparam int M_USER_W   = 2;

  // register select, taken from paddr[2]
  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_ANGLE  = 1'b1;

  // mirrored point order
  typedef enum logic [2:0] {
    OCT_X_NY  = 3'd0,
    OCT_Y_NX  = 3'd1,
    OCT_Y_X   = 3'd2,
    OCT_X_Y   = 3'd3,
    OCT_NX_Y  = 3'd4,
    OCT_NY_X  = 3'd5,
    OCT_NY_NX = 3'd6,
    OCT_NX_NY = 3'd7
  } octant_t;

  // per item control handed from front to back
  typedef struct packed {
    logic [7:0] mask;
    logic       done;
  } mcap_ctrl_t;

  // sine in Q1.15, whole degrees 0..90
  function automatic logic [SIN_W-1:0] sin_q15(input logic [DEG_W-1:0] deg);
    logic [SIN_W-1:0] v;
    case (deg)
      7'd0: v = 16'd0;      7'd1: v = 16'd572;    7'd2: v = 16'd1144;
      7'd3: v = 16'd1715;   7'd4: v = 16'd2286;   7'd5: v = 16'd2856;
      7'd6: v = 16'd3425;   7'd7: v = 16'd3993;   7'd8: v = 16'd4560;
      7'd9: v = 16'd5126;   7'd10: v = 16'd5690;  7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;  7'd13: v = 16'd7371;  7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;  7'd16: v = 16'd9032;  7'd17: v = 16'd9580;
      7'd18: v = 16'd10126; 7'd19: v = 16'd10668; 7'd20: v = 16'd11207;
      7'd21: v = 16'd11743; 7'd22: v = 16'd12275; 7'd23: v = 16'd12803;
      7'd24: v = 16'd13328; 7'd25: v = 16'd13848; 7'd26: v = 16'd14365;
      7'd27: v = 16'd14876; 7'd28: v = 16'd15384; 7'd29: v = 16'd15886;
      7'd30: v = 16'd16384; 7'd31: v = 16'd16877; 7'd32: v = 16'd17364;
      7'd33: v = 16'd17847; 7'd34: v = 16'd18324; 7'd35: v = 16'd18795;
      7'd36: v = 16'd19261; 7'd37: v = 16'd19720; 7'd38: v = 16'd20174;
      7'd39: v = 16'd20622; 7'd40: v = 16'd21063; 7'd41: v = 16'd21498;
      7'd42: v = 16'd21926; 7'd43: v = 16'd22348; 7'd44: v = 16'd22763;
      7'd45: v = 16'd23170; 7'd46: v = 16'd23571; 7'd47: v = 16'd23965;
      7'd48: v = 16'd24351; 7'd49: v = 16'd24730; 7'd50: v = 16'd25102;
      7'd51: v = 16'd25466; 7'd52: v = 16'd25822; 7'd53: v = 16'd26170;
      7'd54: v = 16'd26510; 7'd55: v = 16'd26842; 7'd56: v = 16'd27166;
      7'd57: v = 16'd27482; 7'd58: v = 16'd27789; 7'd59: v = 16'd28088;
      7'd60: v = 16'd28378; 7'd61: v = 16'd28660; 7'd62: v = 16'd28932;
      7'd63: v = 16'd29197; 7'd64: v = 16'd29452; 7'd65: v = 16'd29698;
      7'd66: v = 16'd29935; 7'd67: v = 16'd30163; 7'd68: v = 16'd30382;
      7'd69: v = 16'd30592; 7'd70: v = 16'd30792; 7'd71: v = 16'd30983;
      7'd72: v = 16'd31164; 7'd73: v = 16'd31336; 7'd74: v = 16'd31499;
      7'd75: v = 16'd31651; 7'd76: v = 16'd31795; 7'd77: v = 16'd31928;
      7'd78: v = 16'd32052; 7'd79: v = 16'd32166; 7'd80: v = 16'd32270;
      7'd81: v = 16'd32365; 7'd82: v = 16'd32449; 7'd83: v = 16'd32524;
      7'd84: v = 16'd32588; 7'd85: v = 16'd32643; 7'd86: v = 16'd32688;
      7'd87: v = 16'd32723; 7'd88: v = 16'd32748; 7'd89: v = 16'd32763;
      7'd90: v = 16'd32768;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

>>> src/mcap_front.sv
// ----------------------------------------------------------------------------
// mcap_front
// takes items, steps the midpoint recurrence and works out which octants show
// ----------------------------------------------------------------------------
`include "midpoint_circle_arc_plotter_core_defines.svh"

module mcap_front #(
  parameter int RADIUS_BITS = mcap_pkg::RADIUS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        restart,
  input  logic [RADIUS_BITS-1:0]      arc_radius,
  input  logic [mcap_pkg::ANGLE_W-1:0] arc_angle,
  input  logic                        q_full,
  output logic                        q_push,
  output logic [2*RADIUS_BITS+$bits(mcap_pkg::mcap_ctrl_t)-1:0] q_data
);

  localparam int DEC_W  = RADIUS_BITS + 3;
  localparam int PROD_W = RADIUS_BITS + mcap_pkg::SIN_W;

  // recurrence state
  logic [RADIUS_BITS-1:0]  x_pos, y_pos;
  logic signed [DEC_W-1:0] decision;
  logic                    finished;

  logic [RADIUS_BITS-1:0]  x_next, y_next;
  logic signed [DEC_W-1:0] decision_next;
  logic                    finished_next;
  logic signed [DEC_W-1:0] twice_x, twice_y;

  // snapshot of the position to plot
  logic                   s1_valid;
  logic [RADIUS_BITS-1:0] s1_x, s1_y;
  logic                   s1_done;
  logic                   s1_blank;

  // angle split, with the octant count and sine values held in registers
  logic [mcap_pkg::ANGLE_W-1:0] ang_c, base_c;
  logic [mcap_pkg::OCT_W-1:0]   oct_c, oct_q;
  logic [mcap_pkg::REM_W-1:0]   rem_c;
  logic [mcap_pkg::DEG_W-1:0]   rem_deg;
  logic [mcap_pkg::SIN_W-1:0]   sin_r, cos_r, sin_lo, sin_hi;

  logic [PROD_W-1:0] prod_ys, prod_xc, prod_ylo, prod_xhi;
  logic              even_ok, odd_ok;
  mcap_pkg::mcap_ctrl_t ctrl;

  logic accept;

  assign in_ready = !s1_valid || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid && !q_full;

  assign twice_x = $signed({2'b00, x_pos, 1'b0});
  assign twice_y = $signed({2'b00, y_pos, 1'b0});

  always_comb begin
    x_next        = x_pos;
    y_next        = y_pos;
    decision_next = decision;
    finished_next = finished;
    if (restart) begin
      x_next        = '0;
      y_next        = arc_radius;
      decision_next = DEC_W'(1) - $signed({3'b000, arc_radius});
      finished_next = (arc_radius == '0);
    end else if (!finished) begin
      if (decision < 0) begin
        decision_next = decision + twice_x + DEC_W'(3);
      end else begin
        decision_next = decision + twice_x - twice_y + DEC_W'(5);
        y_next        = y_pos - RADIUS_BITS'(1);
      end
      x_next        = x_pos + RADIUS_BITS'(1);
      finished_next = !(y_next > x_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos    <= '0;
      y_pos    <= '0;
      decision <= '0;
      finished <= 1'b1;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        x_pos    <= x_next;
        y_pos    <= y_next;
        decision <= decision_next;
        finished <= finished_next;
        s1_valid <= 1'b1;
      end else if (q_push) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= x_next;
      s1_y     <= y_next;
      s1_done  <= finished_next;
      s1_blank <= !restart && finished;
    end
  end

  // octant count and remainder of the clamped sweep
  always_comb begin
    ang_c = (arc_angle > mcap_pkg::ANGLE_W'(mcap_pkg::ANGLE_MAX)) ?
            mcap_pkg::ANGLE_W'(mcap_pkg::ANGLE_MAX) : arc_angle;
    oct_c  = '0;
    base_c = '0;
    for (int k = 1; k <= 8; k++) begin
      if (ang_c >= mcap_pkg::ANGLE_W'(mcap_pkg::OCT_SPAN * k)) begin
        oct_c  = mcap_pkg::OCT_W'(k);
        base_c = mcap_pkg::ANGLE_W'(mcap_pkg::OCT_SPAN * k);
      end
    end
    rem_c   = mcap_pkg::REM_W'(ang_c - base_c);
    rem_deg = {1'b0, rem_c};
  end

  always_ff @(posedge clk) begin
    oct_q  <= oct_c;
    sin_r  <= mcap_pkg::sin_q15(rem_deg);
    cos_r  <= mcap_pkg::sin_q15(mcap_pkg::DEG_W'(90) - rem_deg);
    sin_lo <= mcap_pkg::sin_q15(mcap_pkg::DEG_W'(mcap_pkg::OCT_SPAN) - rem_deg);
    sin_hi <= mcap_pkg::sin_q15(mcap_pkg::DEG_W'(mcap_pkg::OCT_SPAN) + rem_deg);
  end

  // slope limits as cross products
  assign prod_ys  = PROD_W'(s1_y) * PROD_W'(sin_r);
  assign prod_xc  = PROD_W'(s1_x) * PROD_W'(cos_r);
  assign prod_ylo = PROD_W'(s1_y) * PROD_W'(sin_lo);
  assign prod_xhi = PROD_W'(s1_x) * PROD_W'(sin_hi);
  assign even_ok  = prod_ys > prod_xc;
  assign odd_ok   = prod_ylo <= prod_xhi;

  always_comb begin
    ctrl.done = s1_done;
    for (int k = 0; k < 8; k++) begin
      ctrl.mask[k] = !s1_blank &&
                     ((oct_q > mcap_pkg::OCT_W'(k)) ||
                      (oct_q == mcap_pkg::OCT_W'(k) && ((k % 2 == 1) ? odd_ok : even_ok)));
    end
  end

  assign q_data = {s1_x, s1_y, ctrl};

  `MCAP_ASSERT_IMPLY(a_blank_done, s1_valid && s1_blank, s1_done,
                     "step on a finished arc not flagged done")

endmodule

>>> src/mcap_queue.sv
// ----------------------------------------------------------------------------
// mcap_queue
// small register queue between the front and the point emitter
// ----------------------------------------------------------------------------
`include "midpoint_circle_arc_plotter_core_defines.svh"

module mcap_queue #(
  parameter int WIDTH = 29,
  parameter int DEPTH = mcap_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  `MCAP_ASSERT_IMPLY(a_no_overflow, push, !full, "push into a full queue")
  `MCAP_ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from an empty queue")

endmodule

>>> src/mcap_back.sv
// ----------------------------------------------------------------------------
// mcap_back
// walks the octant mask of each item, one point per cycle unless stalled
// ----------------------------------------------------------------------------
`include "midpoint_circle_arc_plotter_core_defines.svh"

module mcap_back #(
  parameter int RADIUS_BITS = mcap_pkg::RADIUS_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  logic [2*RADIUS_BITS+$bits(mcap_pkg::mcap_ctrl_t)-1:0] q_head,
  output logic q_pop,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [((2*RADIUS_BITS + 9) / 8) * 8 - 1:0] m_tdata,
  output logic                                      m_tlast,
  output logic [mcap_pkg::M_USER_W-1:0]             m_tuser
);

  localparam int CW     = RADIUS_BITS + 1;
  localparam int DATA_W = ((2*RADIUS_BITS + 9) / 8) * 8;

  logic                   cur_valid;
  logic [7:0]             cur_mask;
  logic [RADIUS_BITS-1:0] cur_x, cur_y;
  logic                   cur_done;

  logic [RADIUS_BITS-1:0] head_x, head_y;
  mcap_pkg::mcap_ctrl_t   head_ctrl;

  logic          out_free, emit, last;
  logic [2:0]    sel;
  logic [7:0]    rem;
  logic [CW-1:0] px, py, xc, yc, nxc, nyc;
  logic          pvalid;

  assign {head_x, head_y, head_ctrl} = q_head;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = cur_valid && out_free;
  assign q_pop    = !q_empty && (!cur_valid || (emit && last));

  assign xc  = CW'(cur_x);
  assign yc  = CW'(cur_y);
  assign nxc = '0 - xc;
  assign nyc = '0 - yc;

  // lowest pending octant goes first
  always_comb begin
    sel = '0;
    for (int k = 7; k >= 0; k--) begin
      if (cur_mask[k]) begin
        sel = 3'(k);
      end
    end
    rem    = cur_mask & ~(8'b1 << sel);
    last   = (rem == '0);
    pvalid = (cur_mask != '0);
  end

  always_comb begin
    case (mcap_pkg::octant_t'(sel))
      mcap_pkg::OCT_X_NY:  begin px = xc;  py = nyc; end
      mcap_pkg::OCT_Y_NX:  begin px = yc;  py = nxc; end
      mcap_pkg::OCT_Y_X:   begin px = yc;  py = xc;  end
      mcap_pkg::OCT_X_Y:   begin px = xc;  py = yc;  end
      mcap_pkg::OCT_NX_Y:  begin px = nxc; py = yc;  end
      mcap_pkg::OCT_NY_X:  begin px = nyc; py = xc;  end
      mcap_pkg::OCT_NY_NX: begin px = nyc; py = nxc; end
      mcap_pkg::OCT_NX_NY: begin px = nxc; py = nyc; end
      default:             begin px = '0;  py = '0;  end
    endcase
    if (!pvalid) begin
      px = '0;
      py = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // the next item loads as the current one sends its last point
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= DATA_W'({py, px});
      m_tuser <= {cur_done, pvalid};
      m_tlast <= last;
    end
    if (q_pop) begin
      cur_mask <= head_ctrl.mask;
      cur_x    <= head_x;
      cur_y    <= head_y;
      cur_done <= head_ctrl.done;
    end else if (emit) begin
      cur_mask <= rem;
    end
  end

  `MCAP_ASSERT_IMPLY(a_empty_is_last, m_tvalid && !m_tuser[0], m_tlast,
                     "empty result not marked last")

endmodule

>>> src/midpoint_circle_arc_plotter_core.sv
// ----------------------------------------------------------------------------
// midpoint_circle_arc_plotter_core
// integer midpoint circle arc with eight-way symmetry and octant clipping
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tdata[0] restart
//  m_*      out  m_tvalid/m_tready  tdata x,y; tuser valid,done; tlast last
//  apb      in   psel/penable       0x0 arc_radius, 0x4 arc_angle
//
//  a new item is taken every cycle while the front stage can hand on to the queue
//  the emitter sends one result per cycle unless m_tready stalls it: an item
//  gives 1 to 8 results, set by the number of octants it draws
//  an item passes the front stage, the queue and the emitter before its output
//  rst: radius 0, angle 360, no arc active; m_tready low stalls the emitter
//  and, once the four-entry queue and the front stage fill, s_tready drops
// ----------------------------------------------------------------------------
module midpoint_circle_arc_plotter_core #(
  parameter int RADIUS_BITS = mcap_pkg::RADIUS_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      s_tvalid,
  output logic                                      s_tready,
  input  logic [mcap_pkg::S_DATA_W-1:0]             s_tdata,  // [0] restart
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  // point_x from bit 0, then point_y, each RADIUS_BITS+1 wide
  output logic [((2*RADIUS_BITS + 9) / 8) * 8 - 1:0] m_tdata,
  output logic                                      m_tlast,
  output logic [mcap_pkg::M_USER_W-1:0]             m_tuser,  // [0] point_valid, [1] arc_done
  input  logic                                      psel,
  input  logic                                      penable,
  input  logic                                      pwrite,
  input  logic [mcap_pkg::APB_ADDR_W-1:0]           paddr,
  input  logic [mcap_pkg::APB_DATA_W-1:0]           pwdata,
  output logic [mcap_pkg::APB_DATA_W-1:0]           prdata,
  output logic                                      pready
);

  localparam int ENTRY_W = 2*RADIUS_BITS + $bits(mcap_pkg::mcap_ctrl_t);

  logic [RADIUS_BITS-1:0]        arc_radius;
  logic [mcap_pkg::ANGLE_W-1:0]  arc_angle;
  logic                          cfg_write;

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arc_radius <= '0;
      arc_angle  <= mcap_pkg::ANGLE_W'(mcap_pkg::ANGLE_MAX);
    end else if (cfg_write) begin
      case (paddr[2])
        mcap_pkg::REG_RADIUS: arc_radius <= pwdata[RADIUS_BITS-1:0];
        mcap_pkg::REG_ANGLE:  arc_angle  <= pwdata[mcap_pkg::ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mcap_pkg::REG_RADIUS: prdata = mcap_pkg::APB_DATA_W'(arc_radius);
      mcap_pkg::REG_ANGLE:  prdata = mcap_pkg::APB_DATA_W'(arc_angle);
      default:              prdata = '0;
    endcase
  end

  mcap_front #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .restart   (s_tdata[0]),
    .arc_radius(arc_radius),
    .arc_angle (arc_angle),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  mcap_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(mcap_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .pop  (q_pop),
    .rdata(q_rdata),
    .full (q_full),
    .empty(q_empty)
  );

  mcap_back #(
    .RADIUS_BITS(RADIUS_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_rdata),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

>>> tb/midpoint_circle_arc_plotter_core_tb.sv
// ----------------------------------------------------------------------------
// midpoint_circle_arc_plotter_core_tb
// drives restart and step items into the arc plotter, mirrors the integer
// midpoint circle walk and the octant clipping in a tracker class, and checks
// every emitted point in order while both stream sides idle and stall at random
// ----------------------------------------------------------------------------

typedef struct packed {
  logic signed [10:0] px;
  logic signed [10:0] py;
  logic               valid;
  logic               last;
  logic               done;
} point_rec_t;

class arc_point_tracker;
  bit [9:0]   radius_r;
  bit [8:0]   angle_r;
  bit [9:0]   xp;
  bit [9:0]   yp;
  int         dec;
  bit         fin;
  int         quarter_sine[91];
  point_rec_t pending_points[$];
  int         errors;
  int         items;
  int         restarts;
  int         results;
  int         points;
  int         settings;

  function new();
    quarter_sine = '{
      0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
      5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
      11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
      16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
      21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
      25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
      28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
      30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
      32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
      32768};
    radius_r = '0;
    angle_r  = 9'd360;
    xp       = '0;
    yp       = '0;
    dec      = 0;
    fin      = 1'b1;
    errors   = 0;
    items    = 0;
    restarts = 0;
    results  = 0;
    points   = 0;
    settings = 0;
  endfunction

  function void write_reg(logic sel, logic [31:0] val);
    if (sel == mcap_pkg::REG_RADIUS) radius_r = val[9:0];
    else angle_r = val[8:0];
    settings++;
  endfunction

  function int pending();
    return pending_points.size();
  endfunction

  function void queue_point(point_rec_t rec);
    pending_points = {pending_points, rec};
  endfunction

  // mirrored points of the current position, clipped by the sweep
  function void plot_octants();
    int                 ang;
    int                 oct;
    int                 rem;
    int                 total;
    int                 n;
    longint             xl;
    longint             yl;
    bit                 even_ok;
    bit                 odd_ok;
    bit                 ok;
    bit [7:0]           drawn;
    logic signed [10:0] sx;
    logic signed [10:0] sy;
    point_rec_t         rec;
    ang = (angle_r > 9'd360) ? 360 : int'(angle_r);
    oct = ang / 45;
    rem = ang % 45;
    xl  = xp;
    yl  = yp;
    even_ok = yl * quarter_sine[rem] > xl * quarter_sine[90 - rem];
    odd_ok  = yl * quarter_sine[45 - rem] <= xl * quarter_sine[45 + rem];
    for (int k = 0; k < 8; k++) begin
      ok = k[0] ? odd_ok : even_ok;
      drawn[k] = (oct > k) || (oct == k && ok);
    end
    total = $countones(drawn);
    sx = {1'b0, xp};
    sy = {1'b0, yp};
    n = 0;
    for (int k = 0; k < 8; k++) begin
      if (drawn[k]) begin
        case (mcap_pkg::octant_t'(k))
          mcap_pkg::OCT_X_NY:  begin rec.px = sx;  rec.py = -sy; end
          mcap_pkg::OCT_Y_NX:  begin rec.px = sy;  rec.py = -sx; end
          mcap_pkg::OCT_Y_X:   begin rec.px = sy;  rec.py = sx;  end
          mcap_pkg::OCT_X_Y:   begin rec.px = sx;  rec.py = sy;  end
          mcap_pkg::OCT_NX_Y:  begin rec.px = -sx; rec.py = sy;  end
          mcap_pkg::OCT_NY_X:  begin rec.px = -sy; rec.py = sx;  end
          mcap_pkg::OCT_NY_NX: begin rec.px = -sy; rec.py = -sx; end
          default:             begin rec.px = -sx; rec.py = -sy; end
        endcase
        n++;
        rec.valid = 1'b1;
        rec.last  = (n == total);
        rec.done  = fin;
        queue_point(rec);
      end
    end
    if (total == 0) queue_point({11'sd0, 11'sd0, 1'b0, 1'b1, fin});
  endfunction

  function void note_item(bit restart);
    items++;
    if (restart) begin
      restarts++;
      xp  = '0;
      yp  = radius_r;
      dec = 1 - int'(yp);
      fin = (yp == 0);
      plot_octants();
    end else if (fin) begin
      queue_point({11'sd0, 11'sd0, 1'b0, 1'b1, 1'b1});
    end else begin
      if (dec < 0) begin
        dec += 2 * int'(xp) + 3;
      end else begin
        dec += 2 * (int'(xp) - int'(yp)) + 5;
        yp = yp - 10'd1;
      end
      xp  = xp + 10'd1;
      fin = !(yp > xp);
      plot_octants();
    end
  endfunction

  task report_mismatch(string what, int got_v, int want_v);
    if (errors < 30) $display("mismatch on result %0d: %s got %0d, expected %0d",
                              results, what, got_v, want_v);
    errors++;
  endtask

  task check_result(point_rec_t got);
    point_rec_t want;
    results++;
    if (got.valid) points++;
    if (pending_points.size() == 0) begin
      report_mismatch("result with nothing pending, x", $signed(got.px), 0);
    end else begin
      want = pending_points.pop_front();
      if (got.px !== want.px) report_mismatch("point_x", $signed(got.px), $signed(want.px));
      if (got.py !== want.py) report_mismatch("point_y", $signed(got.py), $signed(want.py));
      if (got.valid !== want.valid) report_mismatch("point_valid", got.valid, want.valid);
      if (got.last !== want.last) report_mismatch("last_point", got.last, want.last);
      if (got.done !== want.done) report_mismatch("arc_done", got.done, want.done);
    end
  endtask
endclass

module midpoint_circle_arc_plotter_core_tb;

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mcap_pkg::S_DATA_W-1:0]   s_tdata  = '0;   // [0] restart
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mcap_pkg::M_DATA_W-1:0]   m_tdata;         // [10:0] point_x, [21:11] point_y
  logic                            m_tlast;
  logic [mcap_pkg::M_USER_W-1:0]   m_tuser;         // [0] point_valid, [1] arc_done
  logic                            psel     = 1'b0;
  logic                            penable  = 1'b0;
  logic                            pwrite   = 1'b0;
  logic [mcap_pkg::APB_ADDR_W-1:0] paddr    = '0;
  logic [mcap_pkg::APB_DATA_W-1:0] pwdata   = '0;
  logic [mcap_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  arc_point_tracker arc_sb;
  int               idle_pct  = 0;
  int               stall_pct = 0;
  point_rec_t       seen;
  logic             seen_ok   = 1'b0;

  midpoint_circle_arc_plotter_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    m_tready = ($urandom_range(0, 99) >= stall_pct);
  end

  // capture on the rising edge, compare on the falling edge after it so the item
  // that caused it is always noted first
  always @(posedge clk) begin
    seen_ok <= !rst && m_tvalid && m_tready;
    seen    <= {m_tdata[10:0], m_tdata[21:11], m_tuser[0], m_tlast, m_tuser[1]};
  end

  always @(negedge clk) begin
    if (seen_ok) arc_sb.check_result(seen);
  end

  task apb_write(logic sel, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {sel, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    arc_sb.write_reg(sel, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task send_item(bit restart);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {{(mcap_pkg::S_DATA_W-1){1'b0}}, restart};
    do @(posedge clk); while (!s_tready);
    arc_sb.note_item(restart);
  endtask

  task drain_points();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (arc_sb.pending() != 0) @(posedge clk);
  endtask

  // registers only change once every pending point has come out
  task set_arc(int radius, int angle);
    drain_points();
    apb_write(mcap_pkg::REG_RADIUS, radius);
    apb_write(mcap_pkg::REG_ANGLE, angle);
  endtask

  task run_steps(int n);
    repeat (n) send_item(1'b0);
  endtask

  initial begin
    #2_000_000;
    $display("midpoint_circle_arc_plotter_core_tb: done, errors");
    $finish;
  end

  initial begin
    int rad;
    int ang;
    int budget;
    int n;
    arc_sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // step with no arc active, then a zero radius arc
    send_item(1'b0);
    set_arc(0, 360);
    send_item(1'b1);
    send_item(1'b0);
    // largest radius with the sweep over a full turn
    set_arc(1023, 511);
    send_item(1'b1);
    run_steps(2);
    // zero sweep plots nothing
    set_arc(5, 0);
    send_item(1'b1);
    send_item(1'b0);
    set_arc(12, 100);
    send_item(1'b1);
    run_steps(3);
    set_arc(12, 45);
    send_item(1'b1);
    send_item(1'b0);
    // small arc walked past its end
    set_arc(7, 359);
    send_item(1'b1);
    run_steps(6);
    // new radius and angle mid arc: only the angle should bite
    set_arc(9, 270);
    send_item(1'b1);
    send_item(1'b0);
    set_arc(600, 135);
    run_steps(2);

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 9))
        0:       rad = 0;
        1:       rad = 1023;
        2:       rad = $urandom_range(100, 1023);
        default: rad = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0:       ang = 360;
        1:       ang = $urandom_range(361, 511);
        2:       ang = 45 * $urandom_range(0, 8);
        default: ang = $urandom_range(0, 360);
      endcase
      set_arc(rad, ang);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      budget = 20;
      // sometimes carry on with the arc left over from the last phase
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 3);
        run_steps(n);
        budget -= n;
      end
      while (budget > 0) begin
        send_item(1'b1);
        budget--;
        n = $urandom_range(1, rad * 3 / 4 + 4);
        if (n > budget) n = budget;
        repeat (n) send_item($urandom_range(0, 15) == 0);
        budget -= n;
      end
    end

    drain_points();
    stall_pct = 0;
    repeat (16) @(posedge clk);
    $display("run covered %0d items (%0d restarts) over %0d register writes",
             arc_sb.items, arc_sb.restarts, arc_sb.settings);
    $display("checked %0d results, %0d of them plotted points, %0d mismatches",
             arc_sb.results, arc_sb.points, arc_sb.errors);
    if (arc_sb.errors == 0 && arc_sb.pending() == 0)
      $display("midpoint_circle_arc_plotter_core_tb: done, clean");
    else
      $display("midpoint_circle_arc_plotter_core_tb: done, errors");
    $finish;
  end

endmodule
